// File: design/slen_pkg.sv
package slen_pkg;

	localparam int unsigned VALUE_W = 32;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// Status codes on the result channel.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

endpackage

// File: design/slen_ram.sv
module slen_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/sorted_list_engine.sv
// Sorted list engine: holds up to CAPACITY signed 32-bit values in ascending order in a
// single-port-read, single-port-write RAM. Insert (command 0) places the value after all
// equal entries, or answers "full"; delete (command 1) removes the lowest equal entry, or
// answers "not found"; dump (command 2) streams every entry in order with last on the
// final word, or one "empty" word. Each command returns one word with the entry count
// after the operation, except a dump of N entries which returns N words. An insert walks
// the RAM down from the top entry, a delete walks every entry up from the bottom, and a
// dump reads the entries in order, pausing while the output register and hold slot are full.
// One command is worked on at a time; the next is taken once the result is queued in the
// output register, so it may be accepted while that word still waits.
module sorted_list_engine
	import slen_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_ready,
	input  logic [1:0]                            command,
	input  logic signed [VALUE_W-1:0]             operand_value,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [1:0]                            status,
	output logic signed [VALUE_W-1:0]             entry_value,
	output logic [$clog2(CAPACITY+1)-1:0]         entry_count,
	output logic                                  last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS  = 6'b000010,
		S_WRV  = 6'b000100,
		S_DEL  = 6'b001000,
		S_DUMP = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic signed [VALUE_W-1:0] val_q;
	logic [AW-1:0] ptr_q, ptr_d;
	logic issue_q, issue_d;
	logic found_q, found_d;
	logic [1:0] resp_q, resp_d;

	// Read pipeline: a read issued in one cycle returns its data in the next.
	logic pend_s1, pend_d;
	logic [AW-1:0] idx_s1, idx_d;
	logic last_s1, last_d;

	// Output register plus one hold slot for dump words that arrive during a stall.
	logic out_valid_q;
	logic [1:0] status_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CW-1:0] cnt_q;
	logic last_q;
	logic hold_valid_q;
	logic signed [VALUE_W-1:0] hold_value_q;
	logic hold_last_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [VALUE_W-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0] last_idx;
	logic pop, load_free, resp_push, pend_dump, issue_ok, rd_gt;
	logic [1:0] occ;

	slen_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign last_idx  = AW'(count_q - CW'(1));
	assign rd_gt     = $signed(ram_rdata) > val_q;

	assign pop       = out_valid_q && res_ready;
	assign load_free = !out_valid_q || pop;
	assign resp_push = (state_q == S_RESP) && load_free && !hold_valid_q;
	assign pend_dump = pend_s1 && (state_q == S_DUMP);
	assign occ       = 2'(out_valid_q) + 2'(hold_valid_q) + 2'(pend_s1);
	// A dump read may only start when a slot is sure to be free for its word.
	assign issue_ok  = (occ - 2'(pop)) < 2'd2;

	always_comb begin
		logic go_on;
		go_on     = 1'b1;
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		issue_d   = issue_q;
		found_d   = found_q;
		resp_d    = resp_q;
		pend_d    = 1'b0;
		idx_d     = idx_s1;
		last_d    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (command)
						CMD_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								resp_d  = ST_FULL;
								state_d = S_RESP;
							end else if (count_q == '0) begin
								state_d = S_WRV;
							end else begin
								ptr_d   = last_idx;
								issue_d = 1'b1;
								state_d = S_INS;
							end
						end
						CMD_DELETE: begin
							if (count_q == '0) begin
								resp_d  = ST_NOTFOUND;
								state_d = S_RESP;
							end else begin
								ptr_d   = '0;
								issue_d = 1'b1;
								found_d = 1'b0;
								state_d = S_DEL;
							end
						end
						CMD_DUMP: begin
							if (count_q == '0) begin
								resp_d  = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								ptr_d   = '0;
								issue_d = 1'b1;
								state_d = S_DUMP;
							end
						end
						default: begin
							resp_d  = ST_OK;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_INS: begin
				// Walk down from the top, moving each larger entry up by one place.
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 + AW'(1);
					if (rd_gt) begin
						ram_wdata = ram_rdata;
						if (idx_s1 == '0) begin
							go_on   = 1'b0;
							state_d = S_WRV;
						end
					end else begin
						ram_wdata = val_q;
						count_d   = count_q + CW'(1);
						resp_d    = ST_OK;
						go_on     = 1'b0;
						state_d   = S_RESP;
					end
				end
				if (go_on && issue_q) begin
					ram_re  = 1'b1;
					pend_d  = 1'b1;
					idx_d   = ptr_q;
					ptr_d   = ptr_q - AW'(1);
					issue_d = (ptr_q != '0);
				end
			end
			S_WRV: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = val_q;
				count_d   = count_q + CW'(1);
				resp_d    = ST_OK;
				state_d   = S_RESP;
			end
			S_DEL: begin
				// Walk up; once the match is seen, every later entry moves down by one.
				if (pend_s1) begin
					if (!found_q) begin
						found_d = ($signed(ram_rdata) == val_q);
					end else begin
						ram_we    = 1'b1;
						ram_waddr = idx_s1 - AW'(1);
						ram_wdata = ram_rdata;
					end
					if (idx_s1 == last_idx) begin
						go_on   = 1'b0;
						state_d = S_RESP;
						if (found_d) begin
							count_d = count_q - CW'(1);
							resp_d  = ST_OK;
						end else begin
							resp_d = ST_NOTFOUND;
						end
					end
				end
				if (go_on && issue_q) begin
					ram_re  = 1'b1;
					pend_d  = 1'b1;
					idx_d   = ptr_q;
					ptr_d   = ptr_q + AW'(1);
					issue_d = (ptr_q != last_idx);
				end
			end
			S_DUMP: begin
				if (issue_q && issue_ok) begin
					ram_re  = 1'b1;
					pend_d  = 1'b1;
					last_d  = (ptr_q == last_idx);
					ptr_d   = ptr_q + AW'(1);
					issue_d = (ptr_q != last_idx);
				end
				if (!issue_q && !pend_s1 && !hold_valid_q) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (resp_push) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			issue_q      <= 1'b0;
			found_q      <= 1'b0;
			pend_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			issue_q <= issue_d;
			found_q <= found_d;
			pend_s1 <= pend_d;
			if (load_free) begin
				if (hold_valid_q) begin
					out_valid_q  <= 1'b1;
					hold_valid_q <= pend_dump;
				end else if (pend_dump || resp_push) begin
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (pend_dump) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		resp_q <= resp_d;
		idx_s1 <= idx_d;
		last_s1 <= last_d;
		if (cmd_valid && cmd_ready) begin
			val_q <= operand_value;
		end
		if (load_free) begin
			if (hold_valid_q) begin
				status_q <= ST_OK;
				value_q  <= hold_value_q;
				cnt_q    <= count_q;
				last_q   <= hold_last_q;
				if (pend_dump) begin
					hold_value_q <= $signed(ram_rdata);
					hold_last_q  <= last_s1;
				end
			end else if (pend_dump) begin
				status_q <= ST_OK;
				value_q  <= $signed(ram_rdata);
				cnt_q    <= count_q;
				last_q   <= last_s1;
			end else if (resp_push) begin
				status_q <= resp_q;
				value_q  <= '0;
				cnt_q    <= count_q;
				last_q   <= 1'b1;
			end
		end else if (pend_dump) begin
			hold_value_q <= $signed(ram_rdata);
			hold_last_q  <= last_s1;
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = value_q;
	assign entry_count = cnt_q;
	assign last        = last_q;

endmodule

// File: design/slen_checker.sv
module slen_checker
	import slen_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic [1:0]                        command,
	input logic signed [VALUE_W-1:0]         operand_value,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [1:0]                        status,
	input logic signed [VALUE_W-1:0]         entry_value,
	input logic [$clog2(CAPACITY+1)-1:0]     entry_count,
	input logic                              last
);

	localparam int CW = $clog2(CAPACITY + 1);

	// A stalled result word keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(entry_value)
			&& $stable(entry_count) && $stable(last))
		else $error("result word changed while stalled");

	// Any status other than ok ends the command's output at once.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> last)
		else $error("error status without last");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> entry_count == '0 && entry_value == '0)
		else $error("empty word with entries or a value");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> entry_count == CW'(CAPACITY))
		else $error("full word with a count below capacity");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> entry_count <= CW'(CAPACITY))
		else $error("entry count above capacity");

endmodule

bind sorted_list_engine slen_checker #(.CAPACITY(CAPACITY)) u_slen_checker (.*);
